// ===== hdl/mie_pkg.sv =====
// ----------------------------------------------------------------------------
// mie_pkg
// Shared widths, register map and sequencer states for the modular inverse
// block.
// ----------------------------------------------------------------------------
package mie_pkg;

    localparam int WIDTH = 16;
    // Bezout coefficients and their shifted copies stay within a few times
    // the modulus, so two guard bits and a sign bit are enough.
    localparam int CW = WIDTH + 3;
    // Shift count of the divisor: at most WIDTH-1.
    localparam int SH_W = $clog2(WIDTH);

    localparam int DATA_W = 32;
    localparam int ADDR_W = 2;

    localparam logic [ADDR_W-1:0] ADDR_MODULUS = ADDR_W'(0);
    localparam logic [WIDTH-1:0] MODULUS_RESET = WIDTH'(5);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_SUB,
        ST_REDUCE
    } state_t;

endpackage

// ===== hdl/modular_inverse_euclid.sv =====
// ----------------------------------------------------------------------------
// modular_inverse_euclid
// Modular inverse of a value by the extended Euclidean algorithm, with one
// shared shift, compare and subtract datapath under a small sequencer.
// ----------------------------------------------------------------------------
// One value is taken at a time; in_ready is high only while the sequencer is
// idle. Each Euclid step runs a shift-subtract division: the divisor is
// shifted left while it still fits under the dividend, then one quotient bit
// per cycle is resolved while it shifts back, and the coefficient update
// rides along with each subtraction. A final reduction adds or subtracts the
// modulus until the result lies in 0..modulus-1. A value of zero gives zero;
// a modulus of zero gives zero. The modulus register sits at byte address 0
// and may only be written while no item is in flight.
module modular_inverse_euclid (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mie_pkg::ADDR_W-1:0]   paddr,
    input  logic [mie_pkg::DATA_W-1:0]   pwdata,
    output logic [mie_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    // input channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mie_pkg::WIDTH-1:0]    value,
    // output channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mie_pkg::WIDTH-1:0]    inverse
);
    import mie_pkg::*;

    state_t                  state_reg, state_next;
    logic [WIDTH-1:0]        modulus_reg;
    logic [WIDTH-1:0]        ra_reg, ra_next;      // running remainder of dividend
    logic [WIDTH-1:0]        rb_reg, rb_next;      // divisor of this step
    logic [WIDTH-1:0]        d_reg, d_next;        // divisor shifted left by sh
    logic [SH_W-1:0]         sh_reg, sh_next;
    logic signed [CW-1:0]    prev_reg, prev_next;
    logic signed [CW-1:0]    cur_reg, cur_next;
    logic signed [CW-1:0]    nx_reg, nx_next;      // coefficient being built
    logic signed [CW-1:0]    cd_reg, cd_next;      // cur shifted left by sh
    logic                    ovalid_reg, ovalid_next;
    logic [WIDTH-1:0]        inverse_reg, inverse_next;

    logic                    cfg_wr;
    logic                    fits;
    logic                    ge;
    logic [WIDTH-1:0]        ra_sub;
    logic signed [CW-1:0]    nx_sub;
    logic signed [CW-1:0]    mod_s;
    logic                    out_free;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr == ADDR_MODULUS);
    assign prdata   = (paddr == ADDR_MODULUS) ? DATA_W'(modulus_reg) : '0;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;
    assign inverse   = inverse_reg;
    assign out_free  = !ovalid_reg || out_ready;

    // shared datapath
    assign fits   = ({d_reg, 1'b0} <= {1'b0, ra_reg});
    assign ge     = (ra_reg >= d_reg);
    assign ra_sub = ge ? (ra_reg - d_reg) : ra_reg;
    assign nx_sub = ge ? (nx_reg - cd_reg) : nx_reg;
    assign mod_s  = signed'(CW'(modulus_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            modulus_reg <= MODULUS_RESET;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            if (cfg_wr)
            begin
                modulus_reg <= pwdata[WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg      <= ra_next;
        rb_reg      <= rb_next;
        d_reg       <= d_next;
        sh_reg      <= sh_next;
        prev_reg    <= prev_next;
        cur_reg     <= cur_next;
        nx_reg      <= nx_next;
        cd_reg      <= cd_next;
        inverse_reg <= inverse_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        ra_next      = ra_reg;
        rb_next      = rb_reg;
        d_next       = d_reg;
        sh_next      = sh_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        nx_next      = nx_reg;
        cd_next      = cd_reg;
        inverse_next = inverse_reg;
        ovalid_next  = ovalid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ra_next   = value;
                    rb_next   = modulus_reg;
                    d_next    = modulus_reg;
                    sh_next   = '0;
                    prev_next = CW'(1);
                    cur_next  = '0;
                    nx_next   = CW'(1);
                    cd_next   = '0;
                    // a zero modulus skips the loop and reduces to zero
                    state_next = (modulus_reg == '0) ? ST_REDUCE : ST_ALIGN;
                end
            end

            ST_ALIGN:
            begin
                // shift the divisor up while it still fits under the dividend
                if (fits)
                begin
                    d_next  = {d_reg[WIDTH-2:0], 1'b0};
                    cd_next = cd_reg <<< 1;
                    sh_next = sh_reg + SH_W'(1);
                end
                else
                begin
                    state_next = ST_SUB;
                end
            end

            ST_SUB:
            begin
                ra_next = ra_sub;
                nx_next = nx_sub;
                if (sh_reg == '0)
                begin
                    // step done: rotate remainders and coefficients
                    ra_next   = rb_reg;
                    rb_next   = ra_sub;
                    d_next    = ra_sub;
                    prev_next = cur_reg;
                    cur_next  = nx_sub;
                    cd_next   = nx_sub;
                    nx_next   = cur_reg;
                    state_next = (ra_sub == '0) ? ST_REDUCE : ST_ALIGN;
                end
                else
                begin
                    d_next  = d_reg >> 1;
                    cd_next = cd_reg >>> 1;
                    sh_next = sh_reg - SH_W'(1);
                end
            end

            ST_REDUCE:
            begin
                if (modulus_reg == '0)
                begin
                    if (out_free)
                    begin
                        inverse_next = '0;
                        ovalid_next  = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else if (prev_reg < 0)
                begin
                    prev_next = prev_reg + mod_s;
                end
                else if (prev_reg >= mod_s)
                begin
                    prev_next = prev_reg - mod_s;
                end
                else if (out_free)
                begin
                    // hold the result until the previous beat has gone
                    inverse_next = prev_reg[WIDTH-1:0];
                    ovalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== test/modular_inverse_euclid_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_euclid_test
// Self-checking bench for the modular inverse block. Each accepted value
// gets an expectation, typed in the probe table or else computed by an
// extended Euclid predictor under the current modulus, and every result
// beat is checked in order against the oldest expectation. A short table of
// directed probes comes first, then random phases, each under its own
// modulus. Traffic on both channels is throttled at random.
// ----------------------------------------------------------------------------
module modular_inverse_euclid_test;

    import mie_pkg::*;

    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 150;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int N_PROBES    = 21;

    typedef struct packed {
        logic [DATA_W-1:0] modulus_word;
        logic [WIDTH-1:0]  value;
        logic              typed;
        logic [WIDTH-1:0]  inverse;
    } probe_t;

    typedef struct packed {
        logic [WIDTH-1:0] value;
        logic [WIDTH-1:0] modulus;
        logic [WIDTH-1:0] inverse;
    } inverse_rec_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [WIDTH-1:0]   value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [WIDTH-1:0]   inverse;

    inverse_rec_t       pending_inverses [$];
    logic [WIDTH-1:0]   modulus_shadow = MODULUS_RESET;
    int                 mismatches = 0;
    int                 cycle_count = 0;
    int                 burst_left = 0;
    int                 stall_left = 0;
    int                 stall_mode = 0;
    int                 mode_timer = 0;

    // Directed probes; the modulus word carries junk above bit WIDTH-1 in
    // places to check that the register keeps only its own bits.
    probe_t probes [N_PROBES] = '{
        '{32'd5,         16'd0,     1'b1, 16'd0},
        '{32'd5,         16'd1,     1'b1, 16'd1},
        '{32'd5,         16'd2,     1'b0, 16'd0},
        '{32'd5,         16'd3,     1'b0, 16'd0},
        '{32'd5,         16'd4,     1'b1, 16'd4},
        '{32'd65535,     16'd1,     1'b1, 16'd1},
        '{32'd65535,     16'd65534, 1'b1, 16'd65534},
        '{32'd65535,     16'd65535, 1'b1, 16'd0},
        '{32'd65535,     16'd3,     1'b0, 16'd0},
        '{32'd65535,     16'd12345, 1'b0, 16'd0},
        '{32'd65521,     16'd65535, 1'b0, 16'd0},
        '{32'd65521,     16'd65520, 1'b1, 16'd65520},
        '{32'd65521,     16'd32768, 1'b0, 16'd0},
        '{32'd2,         16'd1,     1'b1, 16'd1},
        '{32'd2,         16'd65535, 1'b0, 16'd0},
        '{32'h0001_0001, 16'd65535, 1'b1, 16'd0},
        '{32'h0001_0001, 16'd12345, 1'b1, 16'd0},
        '{32'hA5A5_0000, 16'd0,     1'b1, 16'd0},
        '{32'hA5A5_0000, 16'd65535, 1'b1, 16'd0},
        '{32'd6,         16'd4,     1'b0, 16'd0},
        '{32'd6,         16'd5,     1'b1, 16'd5}
    };

    modular_inverse_euclid u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .inverse   (inverse)
    );

    always #5 clk = ~clk;

    // Extended Euclid on (v, p), tracking the coefficient of v, then reduce
    // the last coefficient into 0..p-1.
    function automatic logic [WIDTH-1:0] predict_inverse(input logic [WIDTH-1:0] v,
                                                         input logic [WIDTH-1:0] p);
        longint rem_hi;
        longint rem_lo;
        longint coef;
        longint coef_last;
        longint coef_next;
        longint quo;
        longint rem;
        longint pm;
        longint reduced;
        rem_hi = v;
        rem_lo = p;
        coef = 0;
        coef_last = 1;
        pm = p;
        if (p == '0)
            return '0;
        while (rem_lo > 0)
        begin
            quo = rem_hi / rem_lo;
            rem = rem_hi - quo * rem_lo;
            coef_next = coef_last - quo * coef;
            rem_hi = rem_lo;
            rem_lo = rem;
            coef_last = coef;
            coef = coef_next;
        end
        reduced = ((coef_last % pm) + pm) % pm;
        return reduced[WIDTH-1:0];
    endfunction

    task automatic read_modulus();
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = ADDR_MODULUS;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== DATA_W'(modulus_shadow))
        begin
            $display("%0t: modulus readback mismatch: expected %0d, got %0d",
                     $time, modulus_shadow, prdata);
            mismatches++;
        end
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic write_modulus(input logic [DATA_W-1:0] word);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = ADDR_MODULUS;
        pwdata = word;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        modulus_shadow = word[WIDTH-1:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        read_modulus();
    endtask

    // Drop valid and hold off until every outstanding inverse has come back.
    task automatic drain_inverses();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_inverses.size() != 0)
            @(posedge clk);
    endtask

    // Bursts of back-to-back beats separated by random gaps.
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = $urandom_range(1, 3);
                2: gap = $urandom_range(4, 20);
                default: gap = $urandom_range(21, 60);
            endcase
            repeat (gap)
            begin
                @(negedge clk);
                in_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    task automatic send_value(input logic [WIDTH-1:0] v, input logic typed,
                              input logic [WIDTH-1:0] typed_inverse);
        inverse_rec_t rec;
        pace_sender();
        @(negedge clk);
        in_valid = 1'b1;
        value = v;
        do @(posedge clk); while (!in_ready);
        rec.value = v;
        rec.modulus = modulus_shadow;
        rec.inverse = typed ? typed_inverse : predict_inverse(v, modulus_shadow);
        pending_inverses.push_back(rec);
    endtask

    function automatic logic [WIDTH-1:0] pick_value(input logic [WIDTH-1:0] p);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return WIDTH'(1);
            2: return p - WIDTH'(1);
            3: return p;
            4: return WIDTH'($urandom_range(0, 15));
            5, 6: return (p > WIDTH'(1)) ? WIDTH'($urandom_range(0, p - 1)) : WIDTH'($urandom);
            default: return WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [WIDTH-1:0] pick_modulus(input int phase);
        case (phase)
            0: return WIDTH'(65535);
            1: return WIDTH'(2);
            2: return WIDTH'(65521);
            3: return WIDTH'($urandom_range(3, 255));
            4: return WIDTH'(32768);
            default: return WIDTH'($urandom_range(2, 65535));
        endcase
    endfunction

    // Receiver: stall pattern switches between free-running, short and long
    // stalls.
    always @(negedge clk)
    begin
        if (mode_timer == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_timer = 256;
        end
        mode_timer--;
        if (stall_left == 0)
        begin
            if (stall_mode == 1 && $urandom_range(0, 2) == 0)
                stall_left = $urandom_range(1, 4);
            else if (stall_mode == 2 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(5, 30);
        end
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        inverse_rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_inverses.size() == 0)
            begin
                $display("%0t: unexpected inverse beat: expected none, got %0d",
                         $time, inverse);
                mismatches++;
            end
            else
            begin
                want = pending_inverses.pop_front();
                if (inverse !== want.inverse)
                begin
                    $display("%0t: inverse of %0d mod %0d: expected %0d, got %0d",
                             $time, want.value, want.modulus, want.inverse, inverse);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d inverses outstanding",
                     $time, pending_inverses.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        logic [WIDTH-1:0] phase_modulus;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // register comes out of reset at its default
        read_modulus();

        for (int i = 0; i < N_PROBES; i++)
        begin
            if (probes[i].modulus_word[WIDTH-1:0] != modulus_shadow)
            begin
                drain_inverses();
                write_modulus(probes[i].modulus_word);
            end
            send_value(probes[i].value, probes[i].typed, probes[i].inverse);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            phase_modulus = pick_modulus(phase);
            drain_inverses();
            write_modulus({16'($urandom), phase_modulus});
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // now and then let the pipe run dry mid-phase
                if ($urandom_range(0, 99) == 0)
                    drain_inverses();
                send_value(pick_value(modulus_shadow), 1'b0, '0);
            end
        end

        drain_inverses();
        repeat (120) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
